// ----- design/fma_pkg.sv -----
`timescale 1ns / 1ps

package fma_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int SET_W     = 7;
	localparam int TBL_LEN_W = 6;

	localparam logic [SET_W-1:0] SET_RESET = 7'd100;

	typedef struct packed {
		logic clear;
		logic rd_en;
		logic upd_en;
	} ring_ctrl_t;

	// window length chosen by smoothing setting, anything off the table is one
	function automatic logic [TBL_LEN_W-1:0] length_for(input logic [SET_W-1:0] s);
		logic [TBL_LEN_W-1:0] len;
		unique case (s)
			7'd0:    len = 6'd40;
			7'd10:   len = 6'd35;
			7'd20:   len = 6'd30;
			7'd30:   len = 6'd25;
			7'd40:   len = 6'd20;
			7'd50:   len = 6'd15;
			7'd60:   len = 6'd10;
			7'd70:   len = 6'd7;
			7'd80:   len = 6'd4;
			7'd90:   len = 6'd2;
			default: len = 6'd1;
		endcase
		return len;
	endfunction

endpackage

// ----- design/fma_ring.sv -----
`timescale 1ns / 1ps

module fma_ring #(
	parameter int MAX_WINDOW = 40,
	parameter int LEN_W      = $clog2(MAX_WINDOW + 1),
	parameter int SUM_W      = 32 + $clog2(MAX_WINDOW)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fma_pkg::ring_ctrl_t        ctrl,
	input  logic signed [31:0]         sample,
	input  logic        [LEN_W-1:0]    length,
	output logic signed [SUM_W-1:0]    sum
);
	import fma_pkg::*;

	localparam int PTR_W = $clog2(MAX_WINDOW);

	logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] rd_q;
	logic        [PTR_W-1:0]    pos_q;
	logic                       full_q;
	logic signed [SUM_W-1:0]    sum_q;

	logic signed [SAMPLE_W-1:0] old;
	logic        [LEN_W-1:0]    pos_inc;
	logic                       wrap;

	// before the first wrap the entry at the position was never written
	assign old     = full_q ? rd_q : '0;
	assign pos_inc = LEN_W'(pos_q) + LEN_W'(1);
	assign wrap    = (pos_inc == length);

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_q <= mem[pos_q];
		end
		if (ctrl.upd_en) begin
			mem[pos_q] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
		end else if (ctrl.clear) begin
			pos_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
		end else if (ctrl.upd_en) begin
			sum_q <= sum_q - SUM_W'(old) + SUM_W'(sample);
			if (wrap) begin
				pos_q  <= '0;
				full_q <= 1'b1;
			end else begin
				pos_q <= pos_inc[PTR_W-1:0];
			end
		end
	end

	assign sum = sum_q;

endmodule

// ----- design/fma_div.sv -----
`timescale 1ns / 1ps

module fma_div #(
	parameter int LEN_W = 6,
	parameter int SUM_W = 38
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    ack,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic        [LEN_W-1:0] divisor,
	output logic                    busy,
	output logic                    done,
	output logic signed [31:0]      quotient
);
	import fma_pkg::*;

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  quo_q;
	logic [LEN_W-1:0]  rem_q;
	logic              neg_q;

	logic [SUM_W-1:0]  mag;
	logic [LEN_W:0]    trial;
	logic [LEN_W:0]    diff;
	logic              ge;
	logic [LEN_W-1:0]  rem_nxt;
	logic [SUM_W-1:0]  signed_quo;

	assign mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
	assign trial   = {rem_q, quo_q[SUM_W-1]};
	assign diff    = trial - {1'b0, divisor};
	assign ge      = (trial >= {1'b0, divisor});
	assign rem_nxt = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(SUM_W);
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (ack) begin
			busy_q <= 1'b0;
		end
	end

	// one quotient bit per cycle, restoring on the magnitude
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q && cnt_q != '0) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign signed_quo = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
	assign busy       = busy_q;
	assign done       = busy_q && (cnt_q == '0);
	assign quotient   = signed_quo[31:0];

endmodule

// ----- design/force_moving_average.sv -----
`timescale 1ns / 1ps

// boxcar moving average of signed 32-bit force samples
// input channel: in_valid / in_stall with force_sample, a beat is taken when
//   in_valid is high and in_stall is low
// output channel: out_valid / out_stall with smoothed_force, one beat per input
// config: cfg_wr_en / cfg_wr_data write the 7-bit smoothing setting; a value
//   different from the current one picks a new window length and clears the
//   history; write only while the block is idle
// processing: an accepted beat has its ring memory entry read, then the sum
//   is updated (S_UPD), the divider is started (S_START) and the bit-serial
//   divider produces one quotient bit per cycle (S_DIV); no new input is taken
//   until the quotient has been handed to the output register
// the output register frees the input side: the next input is taken while a
//   result still waits; if the receiver stalls long enough the divider holds
//   its result and the input stalls until the output register drains
// reset: setting 100 (window of one), sum, position and history cleared; the
//   ring memory needs no clearing pass, entries not yet written read as zero
module force_moving_average #(
	parameter int MAX_WINDOW = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] force_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] smoothed_force,
	input  logic               cfg_wr_en,
	input  logic        [6:0]  cfg_wr_data
);
	import fma_pkg::*;

	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = 32 + $clog2(MAX_WINDOW);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_UPD   = 4'b0010,
		S_START = 4'b0100,
		S_DIV   = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [SET_W-1:0]         setting_q;
	logic [LEN_W-1:0]         len_q;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                     out_valid_q;
	logic signed [SAMPLE_W-1:0] out_q;

	ring_ctrl_t               ring_ctrl;
	logic signed [SUM_W-1:0]  sum;
	logic                     accept;
	logic                     div_start;
	logic                     div_ack;
	logic                     div_busy;
	logic                     div_done;
	logic signed [31:0]       quotient;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign div_start = (state_q == S_START);
	assign div_ack   = div_done && (!out_valid_q || !out_stall);

	assign ring_ctrl.clear  = cfg_wr_en && (cfg_wr_data != setting_q);
	assign ring_ctrl.rd_en  = accept;
	assign ring_ctrl.upd_en = (state_q == S_UPD);

	fma_ring #(
		.MAX_WINDOW(MAX_WINDOW),
		.LEN_W     (LEN_W),
		.SUM_W     (SUM_W)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ring_ctrl),
		.sample(sample_s1),
		.length(len_q),
		.sum   (sum)
	);

	fma_div #(
		.LEN_W(LEN_W),
		.SUM_W(SUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.ack     (div_ack),
		.dividend(sum),
		.divisor (len_q),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_UPD;
				end
				S_UPD:   state_q <= S_START;
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (div_ack) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting_q <= SET_RESET;
			len_q     <= LEN_W'(length_for(SET_RESET));
		end else if (ring_ctrl.clear) begin
			setting_q <= cfg_wr_data;
			len_q     <= LEN_W'(length_for(cfg_wr_data));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= force_sample;
		end
		if (div_ack) begin
			out_q <= quotient;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_ack) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign smoothed_force = out_q;

	a_accept_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_UPD))
		else $error("accepted beat did not enter the update cycle");

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_load_free_out: assert property (@(posedge clk) disable iff (!arst_n)
		div_ack |-> (!out_valid || !out_stall))
		else $error("result loaded over a stalled output beat");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider result outside the divide state");

endmodule
